// ===== hw/rtl/ttb_pkg.sv =====
// Shared types and constants for the triangle tangent/bitangent unit.
package ttb_pkg;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned DeltaW  = 17;
  localparam int unsigned NumW    = 35;   // products of deltas, differences of two
  localparam int unsigned DetW    = 35;
  localparam int unsigned OutW    = 32;
  localparam int unsigned QW      = 58;   // quotient width before saturation
  localparam int unsigned DivSteps = 58;
  localparam int unsigned NumComp = 6;
  localparam int unsigned QueueDepth = 2;

  // One triangle's work, from the front end to the divider back end.
  typedef struct packed {
    logic signed [NumW-1:0] num_tx;
    logic signed [NumW-1:0] num_ty;
    logic signed [NumW-1:0] num_tz;
    logic signed [NumW-1:0] num_bx;
    logic signed [NumW-1:0] num_by;
    logic signed [NumW-1:0] num_bz;
    logic signed [DetW-1:0] det;
  } tri_job_t;

  typedef struct packed {
    logic                   valid;
    logic                   stall;
  } hs_t;

endpackage

// ===== hw/rtl/ttb_front.sv =====
// Front end: holds three vertices, forms deltas, numerators and determinant.
module ttb_front import ttb_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [CoordW-1:0] pos_x_i,
  input  logic signed [CoordW-1:0] pos_y_i,
  input  logic signed [CoordW-1:0] pos_z_i,
  input  logic signed [CoordW-1:0] tex_u_i,
  input  logic signed [CoordW-1:0] tex_v_i,
  input  logic                     end_of_object_i,
  output logic                     job_valid_o,
  input  logic                     job_stall_i,
  output tri_job_t                 job_o
);

  localparam logic [1:0] PhDelta = 2'd0;
  localparam logic [1:0] PhProd  = 2'd1;

  logic [1:0] cnt_q, cnt_d;
  logic signed [CoordW-1:0] v0_q [5];
  logic signed [CoordW-1:0] v1_q [5];
  logic        busy_q, busy_d;
  logic [1:0]  ph_q, ph_d;
  logic signed [DeltaW-1:0] dp1_q [3];
  logic signed [DeltaW-1:0] dp2_q [3];
  logic signed [DeltaW-1:0] du1_q, dv1_q, du2_q, dv2_q;
  logic        out_v_q, out_v_d;
  tri_job_t    job_q;
  logic        accept;
  logic        third;

  assign in_stall_o  = busy_q | (out_v_q & job_stall_i);
  assign accept      = in_valid_i & ~in_stall_o;
  assign third       = (cnt_q == 2'd2);
  assign job_valid_o = out_v_q;
  assign job_o       = job_q;

  always_comb begin
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    ph_d    = ph_q;
    out_v_d = out_v_q & job_stall_i;
    if (accept) begin
      cnt_d = third ? 2'd0 : ((cnt_q == 2'd1) ? 2'd2 : 2'd1);
      if (end_of_object_i) cnt_d = 2'd0;
      if (third) begin
        busy_d = 1'b1;
        ph_d   = PhDelta;
      end
    end else if (busy_q) begin
      unique case (ph_q)
        PhDelta: ph_d = PhProd;
        default: begin
          busy_d  = 1'b0;
          out_v_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= 2'd0;
      busy_q  <= 1'b0;
      ph_q    <= PhDelta;
      out_v_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      busy_q  <= busy_d;
      ph_q    <= ph_d;
      out_v_q <= out_v_d;
    end
  end

  logic signed [CoordW-1:0] vin [5];
  assign vin[0] = pos_x_i;
  assign vin[1] = pos_y_i;
  assign vin[2] = pos_z_i;
  assign vin[3] = tex_u_i;
  assign vin[4] = tex_v_i;

  // Hold vertices; the third vertex goes to its own slot and leaves the first two intact.
  logic signed [CoordW-1:0] v2_q [5];
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < 5; i++) begin
        if (third) v2_q[i] <= vin[i];
        else if (cnt_q == 2'd1) v1_q[i] <= vin[i];
        else v0_q[i] <= vin[i];
      end
    end
    if (busy_q && ph_q == PhDelta) begin
      for (int i = 0; i < 3; i++) begin
        dp1_q[i] <= DeltaW'(v1_q[i]) - DeltaW'(v0_q[i]);
        dp2_q[i] <= DeltaW'(v2_q[i]) - DeltaW'(v0_q[i]);
      end
      du1_q <= DeltaW'(v1_q[3]) - DeltaW'(v0_q[3]);
      dv1_q <= DeltaW'(v1_q[4]) - DeltaW'(v0_q[4]);
      du2_q <= DeltaW'(v2_q[3]) - DeltaW'(v0_q[3]);
      dv2_q <= DeltaW'(v2_q[4]) - DeltaW'(v0_q[4]);
    end
    if (busy_q && ph_q == PhProd) begin
      job_q.num_tx <= NumW'(dp1_q[0] * dv2_q) - NumW'(dp2_q[0] * dv1_q);
      job_q.num_ty <= NumW'(dp1_q[1] * dv2_q) - NumW'(dp2_q[1] * dv1_q);
      job_q.num_tz <= NumW'(dp1_q[2] * dv2_q) - NumW'(dp2_q[2] * dv1_q);
      job_q.num_bx <= NumW'(dp2_q[0] * du1_q) - NumW'(dp1_q[0] * du2_q);
      job_q.num_by <= NumW'(dp2_q[1] * du1_q) - NumW'(dp1_q[1] * du2_q);
      job_q.num_bz <= NumW'(dp2_q[2] * du1_q) - NumW'(dp1_q[2] * du2_q);
      job_q.det    <= NumW'(du1_q * dv2_q) - NumW'(dv1_q * du2_q);
    end
  end

endmodule

// ===== hw/rtl/ttb_queue.sv =====
// Two-entry request queue between front end and divider back end.
module ttb_queue import ttb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     wr_valid_i,
  output logic     wr_stall_o,
  input  tri_job_t wr_data_i,
  output logic     rd_valid_o,
  input  logic     rd_stall_i,
  output tri_job_t rd_data_o
);

  tri_job_t   mem_q [QueueDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_stall_o = (cnt_q == 2'(QueueDepth));
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i & ~wr_stall_o;
  assign rd = rd_valid_o & ~rd_stall_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'(QueueDepth))
    else $error("queue count overrun");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> (wp_q == rp_q)) else $error("empty queue pointers differ");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'(QueueDepth)) |-> (wp_q == rp_q)) else $error("full queue pointers differ");

endmodule

// ===== hw/rtl/ttb_divider.sv =====
// Back end: restoring divider, one quotient bit per cycle, six components.
module ttb_divider import ttb_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   job_valid_i,
  output logic                   job_stall_o,
  input  tri_job_t               job_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [OutW-1:0] tangent_x_o,
  output logic signed [OutW-1:0] tangent_y_o,
  output logic signed [OutW-1:0] tangent_z_o,
  output logic signed [OutW-1:0] bitangent_x_o,
  output logic signed [OutW-1:0] bitangent_y_o,
  output logic signed [OutW-1:0] bitangent_z_o,
  output logic                   degenerate_o,
  output logic                   saturated_o
);

  localparam int unsigned DvW = QW;   // dividend bits = |n|<<21 + |d|
  localparam int unsigned DsW = DetW + 1;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]  st_q, st_d;
  tri_job_t    job_q;
  logic [2:0]  comp_q;
  logic [5:0]  bit_q;
  logic [DvW-1:0] dvd_q;
  logic [DsW-1:0] rem_q;
  logic [DsW-1:0] ds_q;
  logic [QW-1:0]  quo_q;
  logic        neg_q;
  logic [OutW-1:0] res_q [NumComp];
  logic        sat_q, deg_q;
  logic        out_v_q;
  logic        st_init_pending_q;

  logic signed [NumW-1:0] cur_n;
  logic [NumW-1:0] abs_n;
  logic [DetW-1:0] abs_d;
  logic            cur_neg;
  logic [DsW:0]    trial;
  logic [QW-1:0]   quo_next;
  logic [OutW-1:0] sat_val;
  logic            sat_hit;

  always_comb begin
    unique case (comp_q)
      3'd0: cur_n = job_q.num_tx;
      3'd1: cur_n = job_q.num_ty;
      3'd2: cur_n = job_q.num_tz;
      3'd3: cur_n = job_q.num_bx;
      3'd4: cur_n = job_q.num_by;
      default: cur_n = job_q.num_bz;
    endcase
  end
  assign abs_n   = cur_n[NumW-1] ? NumW'(-cur_n) : NumW'(cur_n);
  assign abs_d   = job_q.det[DetW-1] ? DetW'(-job_q.det) : DetW'(job_q.det);
  assign cur_neg = cur_n[NumW-1] ^ job_q.det[DetW-1];

  assign trial    = {rem_q, dvd_q[DvW-1]} - {1'b0, ds_q};
  assign quo_next = {quo_q[QW-2:0], ~trial[DsW]};

  always_comb begin
    sat_hit = 1'b0;
    if (neg_q) begin
      if (quo_next > QW'(33'h80000000)) begin
        sat_val = 32'h80000000;
        sat_hit = 1'b1;
      end else sat_val = OutW'(-quo_next);
    end else if (quo_next > QW'(32'h7FFFFFFF)) begin
      sat_val = 32'h7FFFFFFF;
      sat_hit = 1'b1;
    end else sat_val = OutW'(quo_next);
  end

  assign job_stall_o = (st_q != StIdle);
  assign out_valid_o = out_v_q;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (job_valid_i) st_d = StDiv;
      StDiv: begin
        if (deg_q || (bit_q == 6'(DivSteps - 1) && comp_q == 3'(NumComp - 1))) st_d = StDone;
      end
      StDone: if (!out_v_q || !out_stall_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == StDone && (!out_v_q || !out_stall_i)) out_v_q <= 1'b1;
      else if (!out_stall_i) out_v_q <= 1'b0;
    end
  end

  // Dividend is |n|*2^21 + |d|, divisor 2*|d|: rounds half away from zero.
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      StIdle: begin
        job_q  <= job_i;
        comp_q <= 3'd0;
        sat_q  <= 1'b0;
        deg_q  <= (job_i.det == '0);
        st_init_pending_q <= 1'b1;
      end
      StDiv: begin
        if (st_init_pending_q) begin
          dvd_q  <= (DvW'(abs_n) << 21) + DvW'(abs_d);
          ds_q   <= {abs_d, 1'b0};
          rem_q  <= '0;
          quo_q  <= '0;
          bit_q  <= '0;
          neg_q  <= cur_neg;
          st_init_pending_q <= 1'b0;
        end else begin
          rem_q <= trial[DsW] ? {rem_q[DsW-2:0], dvd_q[DvW-1]} : trial[DsW-1:0];
          dvd_q <= {dvd_q[DvW-2:0], 1'b0};
          quo_q <= quo_next;
          bit_q <= bit_q + 6'd1;
          if (bit_q == 6'(DivSteps - 1)) begin
            res_q[comp_q] <= sat_val;
            sat_q <= sat_q | sat_hit;
            comp_q <= comp_q + 3'd1;
            st_init_pending_q <= 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (st_q == StDone && (!out_v_q || !out_stall_i)) begin
      tangent_x_o   <= deg_q ? '0 : res_q[0];
      tangent_y_o   <= deg_q ? '0 : res_q[1];
      tangent_z_o   <= deg_q ? '0 : res_q[2];
      bitangent_x_o <= deg_q ? '0 : res_q[3];
      bitangent_y_o <= deg_q ? '0 : res_q[4];
      bitangent_z_o <= deg_q ? '0 : res_q[5];
      degenerate_o  <= deg_q;
      saturated_o   <= deg_q ? 1'b0 : sat_q;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_stall_i) |=> out_v_q) else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StDiv) |-> (comp_q < 3'(NumComp))) else $error("component index overrun");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StDiv) |-> (st_q != StIdle)) else $error("busy flag");

endmodule

// ===== hw/rtl/triangle_tangent_bitangent.sv =====
// Per-triangle tangent/bitangent unit: vertex front end, queue, divider back end.
// Vertices are taken one per cycle for the first two of a triangle while the
// input is not stalled; the third starts delta and product work in the front
// end (phases PhDelta then PhProd), during which the input stalls, after which
// the job goes to a two-entry queue. The back end divides each of the six
// components with a bit-serial restoring divider (a setup step, then 58
// quotient bits, per component), so sustained rate is set by that divider; the
// input stalls once the queue is full and the front end holds a finished job.
// Degenerate triangles (zero UV determinant) skip the division and finish with
// zero vectors.
module triangle_tangent_bitangent import ttb_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [CoordW-1:0] pos_x_i,
  input  logic signed [CoordW-1:0] pos_y_i,
  input  logic signed [CoordW-1:0] pos_z_i,
  input  logic signed [CoordW-1:0] tex_u_i,
  input  logic signed [CoordW-1:0] tex_v_i,
  input  logic                     end_of_object_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [OutW-1:0]   tangent_x_o,
  output logic signed [OutW-1:0]   tangent_y_o,
  output logic signed [OutW-1:0]   tangent_z_o,
  output logic signed [OutW-1:0]   bitangent_x_o,
  output logic signed [OutW-1:0]   bitangent_y_o,
  output logic signed [OutW-1:0]   bitangent_z_o,
  output logic                     degenerate_o,
  output logic                     saturated_o
);

  logic     f_valid, f_stall, b_valid, b_stall;
  tri_job_t f_job, b_job;

  ttb_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .pos_x_i, .pos_y_i, .pos_z_i, .tex_u_i, .tex_v_i, .end_of_object_i,
    .job_valid_o(f_valid), .job_stall_i(f_stall), .job_o(f_job)
  );

  ttb_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_stall_o(f_stall), .wr_data_i(f_job),
    .rd_valid_o(b_valid), .rd_stall_i(b_stall), .rd_data_o(b_job)
  );

  ttb_divider u_div (
    .clk_i, .rst_ni,
    .job_valid_i(b_valid), .job_stall_o(b_stall), .job_i(b_job),
    .out_valid_o, .out_stall_i,
    .tangent_x_o, .tangent_y_o, .tangent_z_o,
    .bitangent_x_o, .bitangent_y_o, .bitangent_z_o,
    .degenerate_o, .saturated_o
  );

endmodule
